FILE: design/wgm_pkg.sv
package wgm_pkg;

	// Longest pattern the position chain can track.
	localparam int PATTERN_MAX = 16;

	// Pattern bytes that the two character registers hold.
	localparam int STORED_BYTES = 16;

	// Longest pattern in effect once the length register is saturated.
	localparam int LEN_CAP = (PATTERN_MAX < STORED_BYTES) ? PATTERN_MAX : STORED_BYTES;

	// Width of a position index, 0 up to PATTERN_MAX inclusive.
	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	// Width of the pattern length register.
	localparam int CFG_LEN_W = 5;

	// Wildcard bytes.
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_ANY  = 8'h3F;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PAT_LOW  = 2'd0;
	localparam logic [1:0] CFG_PAT_HIGH = 2'd1;
	localparam logic [1:0] CFG_PAT_LEN  = 2'd2;

	// One request on the text channel.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_last;
	} text_req_t;

	// One result on the verdict channel.
	typedef struct packed {
		logic matches_here;
		logic was_last;
	} result_t;

	// Controls broadcast to every cell of the position chain.
	typedef struct packed {
		logic       step;
		logic       load;
		logic [7:0] text_byte;
	} cell_ctrl_t;

	// Signals one cell hands to its right-hand neighbor.
	typedef struct packed {
		logic adv;
		logic clos;
		logic start;
	} link_t;

endpackage

FILE: design/wildcard_glob_matcher_unit.sv
// Channel  | Direction | Handshake                  | Payload
// text     | in        | text_valid / text_ready    | text_req_t: text_byte, is_last
// result   | out       | result_valid / result_ready| result_t: matches_here, was_last
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index (2 bits), cfg_data (64 bits)
//
// One text byte is taken per cycle while text_ready is high; its verdict is registered.
// The clock period is set by the star-closure ripple through the chain of position cells.
// A two-entry output buffer lets requests continue while a result waits to be taken.
// text_ready is low in the cycle after reset and after each register write, while
// the start set of the pattern is loaded into the cells.
// cfg_ready is always high; writes to an unknown index are dropped.
module wildcard_glob_matcher_unit import wgm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  text_req_t   text,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]                pat_low_q;
	logic [63:0]                pat_high_q;
	logic [CFG_LEN_W-1:0]       pat_len_q;
	logic                       settle_q;
	logic [STORED_BYTES*8-1:0]  pat_bytes;
	logic [LEN_W-1:0]           len_eff;
	logic                       cfg_fire;
	logic                       cfg_known;
	logic                       text_fire;
	logic                       skid_ready;
	cell_ctrl_t                 ctrl;
	result_t                    verdict;
	logic [7:0]                 cell_byte [0:PATTERN_MAX];
	logic [PATTERN_MAX:0]       cell_in_range;
	logic [PATTERN_MAX:0]       next_vec;
	logic [PATTERN_MAX:0]       active_vec;
	link_t                      links [0:PATTERN_MAX];

	// Configuration registers.
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_comb begin
		case (cfg_index)
			CFG_PAT_LOW, CFG_PAT_HIGH, CFG_PAT_LEN: cfg_known = 1'b1;
			default:                                 cfg_known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_fire) begin
			case (cfg_index)
				CFG_PAT_LOW:  pat_low_q  <= cfg_data;
				CFG_PAT_HIGH: pat_high_q <= cfg_data;
				CFG_PAT_LEN:  pat_len_q  <= cfg_data[CFG_LEN_W-1:0];
				default:      pat_len_q  <= pat_len_q;
			endcase
		end
	end

	// The settle flag, set by reset or a write to a known register, loads the new start set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_fire && cfg_known;
		end
	end

	// Saturate the pattern length.
	always_comb begin
		if (pat_len_q > CFG_LEN_W'(LEN_CAP)) begin
			len_eff = LEN_W'(LEN_CAP);
		end else begin
			len_eff = LEN_W'(pat_len_q);
		end
	end

	assign pat_bytes = {pat_high_q, pat_low_q};

	// Text handshake and broadcast controls.
	assign text_ready = skid_ready && !settle_q;
	assign text_fire  = text_valid && text_ready;

	always_comb begin
		ctrl.step      = text_fire && !text.is_last;
		ctrl.load      = settle_q || (text_fire && text.is_last);
		ctrl.text_byte = text.text_byte;
	end

	// Head of the chain: position zero is always in the start set.
	always_comb begin
		links[0].adv   = 1'b0;
		links[0].clos  = 1'b0;
		links[0].start = 1'b1;
	end

	// Chain of position cells.
	for (genvar j = 0; j <= PATTERN_MAX; j++) begin : g_cell
		if (j < STORED_BYTES) begin : g_byte
			assign cell_byte[j] = pat_bytes[8*j +: 8];
		end else begin : g_pad
			assign cell_byte[j] = 8'h00;
		end

		assign cell_in_range[j] = (len_eff > LEN_W'(j));

		if (j < PATTERN_MAX) begin : g_mid
			wgm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.pat_byte (cell_byte[j]),
				.in_range (cell_in_range[j]),
				.ctrl     (ctrl),
				.link_in  (links[j]),
				.link_out (links[j+1]),
				.next_bit (next_vec[j]),
				.active   (active_vec[j])
			);
		end else begin : g_tail
			wgm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.pat_byte (cell_byte[j]),
				.in_range (cell_in_range[j]),
				.ctrl     (ctrl),
				.link_in  (links[j]),
				.link_out (),
				.next_bit (next_vec[j]),
				.active   (active_vec[j])
			);
		end
	end

	// Verdict: the position at the pattern end is live after this byte.
	always_comb begin
		verdict.matches_here = next_vec[len_eff];
		verdict.was_last     = text.is_last;
	end

	wgm_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (text_fire),
		.in_ready  (skid_ready),
		.in_data   (verdict),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

	// Every accepted request yields a pending result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		text_fire |=> result_valid)
		else $error("accepted text byte left no pending result");

	// A register write blocks text for the following cycle.
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_fire && cfg_known) |=> !text_ready)
		else $error("text accepted before start set was reloaded");

	// Loading the start set always activates position zero.
	a_start_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> active_vec[0])
		else $error("position zero missing after start set load");

endmodule

FILE: design/wgm_cell.sv
module wgm_cell import wgm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] pat_byte,
	input  logic       in_range,
	input  cell_ctrl_t ctrl,
	input  link_t      link_in,
	output link_t      link_out,
	output logic       next_bit,
	output logic       active
);

	logic active_q;
	logic is_star;
	logic lit_ok;
	logic stay;

	// Classify this pattern byte against the incoming text byte.
	assign is_star = in_range && (pat_byte == CHAR_STAR);
	assign lit_ok  = in_range && !is_star &&
		((pat_byte == CHAR_ANY) || (pat_byte == ctrl.text_byte));

	// A live star keeps its own position; the left neighbor may advance into it.
	assign stay     = active_q && is_star;
	assign next_bit = stay || link_in.adv || link_in.clos;

	// Hand advance, star closure and start set to the next position.
	always_comb begin
		link_out.adv   = active_q && lit_ok;
		link_out.clos  = next_bit && is_star;
		link_out.start = link_in.start && is_star;
	end

	// Position bit: load the start set, or take the stepped value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctrl.load) begin
			active_q <= link_in.start;
		end else if (ctrl.step) begin
			active_q <= next_bit;
		end
	end

	assign active = active_q;

endmodule

FILE: design/wgm_out_skid.sv
module wgm_out_skid import wgm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    in_fire;
	logic    out_free;

	// Upstream sees only the skid slot, so no path runs from out_ready.
	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || out_ready;

	// Control: output slot refills from the skid slot first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_fire) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench import wgm_pkg::*; ();

	// Index that no register answers to; writes to it must leave the matcher alone.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_ready;
	text_req_t   text;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	wildcard_glob_matcher_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text         (text),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Requests waiting for the driver and verdicts waiting for the matcher.
	text_req_t pending_text[$];
	result_t   expected_verdicts[$];
	int        items_pushed = 0;
	int        items_taken = 0;
	int        fail_count = 0;
	logic      text_fire = 1'b0;

	// Shadow copy of the pattern registers and the live position set.
	logic [63:0]          pat_lo_q;
	logic [63:0]          pat_hi_q;
	logic [CFG_LEN_W-1:0] pat_len_q;
	logic [PATTERN_MAX:0] live_pos;

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = ~clk;
	end

	// Pattern byte i as the two character registers hold it.
	function automatic logic [7:0] glob_byte(int i);
		if (i < 8) begin
			return pat_lo_q[8 * i +: 8];
		end
		if (i < 16) begin
			return pat_hi_q[8 * (i - 8) +: 8];
		end
		return 8'h00;
	endfunction

	// Pattern length after saturation.
	function automatic int glob_len();
		int n;
		n = pat_len_q;
		if (n > LEN_CAP) begin
			n = LEN_CAP;
		end
		return n;
	endfunction

	// A live position sitting on a star also makes the next position live.
	function automatic logic [PATTERN_MAX:0] close_stars(logic [PATTERN_MAX:0] s);
		int n;
		n = glob_len();
		for (int i = 0; i < n; i++) begin
			if (s[i] && glob_byte(i) == CHAR_STAR) begin
				s[i + 1] = 1'b1;
			end
		end
		return s;
	endfunction

	function automatic logic [PATTERN_MAX:0] start_positions();
		logic [PATTERN_MAX:0] s;
		s = '0;
		s[0] = 1'b1;
		return close_stars(s);
	endfunction

	// A write to a known register reloads the start set and drops the string in progress.
	function automatic void apply_write(logic [1:0] idx, logic [63:0] data);
		case (idx)
			CFG_PAT_LOW: begin
				pat_lo_q = data;
			end
			CFG_PAT_HIGH: begin
				pat_hi_q = data;
			end
			CFG_PAT_LEN: begin
				pat_len_q = data[CFG_LEN_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		live_pos = start_positions();
	endfunction

	// Moves the position set over one text byte and returns the verdict.
	function automatic logic advance_positions(logic [7:0] c, logic last);
		logic [PATTERN_MAX:0] nxt;
		logic [7:0]           p;
		logic                 hit;
		int                   n;
		n = glob_len();
		nxt = '0;
		for (int i = 0; i < n; i++) begin
			if (live_pos[i]) begin
				p = glob_byte(i);
				if (p == CHAR_STAR) begin
					nxt[i] = 1'b1;
				end else if (p == CHAR_ANY || p == c) begin
					nxt[i + 1] = 1'b1;
				end
			end
		end
		live_pos = close_stars(nxt);
		hit = live_pos[n];
		if (last) begin
			live_pos = start_positions();
		end
		return hit;
	endfunction

	// Text bytes lean on a small alphabet so that literals hit often.
	function automatic logic [7:0] text_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 8'h61 + 8'($urandom_range(0, 2));
		end
		if (r == 6) begin
			return CHAR_STAR;
		end
		if (r == 7) begin
			return CHAR_ANY;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pattern_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) begin
			return CHAR_STAR;
		end
		if (r < 5) begin
			return CHAR_ANY;
		end
		if (r < 9) begin
			return 8'h61 + 8'($urandom_range(0, 2));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [63:0] pattern_word();
		logic [63:0] w;
		if ($urandom_range(0, 3) == 0) begin
			return {$urandom, $urandom};
		end
		for (int i = 0; i < 8; i++) begin
			w[8 * i +: 8] = pattern_pick();
		end
		return w;
	endfunction

	task automatic push_text(input logic [7:0] b, input logic last);
		pending_text.push_back(text_req_t'{text_byte: b, is_last: last});
		items_pushed++;
	endtask

	// Builds one string, mostly one the pattern should accept, sometimes damaged or pure noise.
	task automatic queue_string(input bit shaped);
		logic [7:0] s[$];
		int         n;
		n = glob_len();
		if (shaped) begin
			for (int i = 0; i < n; i++) begin
				if (glob_byte(i) == CHAR_STAR) begin
					repeat ($urandom_range(0, 3)) s.push_back(text_pick());
				end else if (glob_byte(i) == CHAR_ANY) begin
					s.push_back(text_pick());
				end else begin
					s.push_back(glob_byte(i));
				end
			end
			// Damage about a quarter of the well-formed strings.
			if (s.size() != 0 && $urandom_range(0, 3) == 0) begin
				s[$urandom_range(0, s.size() - 1)] = text_pick();
			end
		end else begin
			repeat ($urandom_range(1, 12)) s.push_back(text_pick());
		end
		if (s.size() == 0) begin
			s.push_back(text_pick());
		end
		foreach (s[k]) begin
			push_text(s[k], k == s.size() - 1);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every request has been taken and every verdict has come back.
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (items_taken != items_pushed || expected_verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_random_pattern();
		logic [63:0] len_word;
		int          r;
		r = $urandom_range(0, 9);
		len_word = {$urandom, $urandom};
		if (r == 0) begin
			len_word[CFG_LEN_W-1:0] = '0;
		end else if (r == 1) begin
			len_word[CFG_LEN_W-1:0] = CFG_LEN_W'($urandom_range(LEN_CAP + 1, 31));
		end else if (r == 2) begin
			len_word[CFG_LEN_W-1:0] = CFG_LEN_W'(LEN_CAP);
		end else begin
			len_word[CFG_LEN_W-1:0] = CFG_LEN_W'($urandom_range(1, LEN_CAP));
		end
		// Now and then only the length changes and the characters stay.
		if ($urandom_range(0, 4) != 0) begin
			write_reg(CFG_PAT_LOW, pattern_word());
			write_reg(CFG_PAT_HIGH, pattern_word());
		end
		write_reg(CFG_PAT_LEN, len_word);
		if ($urandom_range(0, 5) == 0) begin
			write_reg(CFG_UNUSED, {$urandom, $urandom});
		end
		end_writes();
	endtask

	// Text driver: bursts of requests separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!text_valid || text_fire) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				text_valid <= 1'b0;
			end else if (pending_text.size() != 0) begin
				text <= pending_text.pop_front();
				text_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// Result receiver: runs of ready and stalls of mixed length.
	int rx_left = 0;

	always @(negedge clk) begin
		int r;
		if (rx_left == 0) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				result_ready <= 1'b1;
				rx_left <= $urandom_range(1, 30);
			end else if (r < 8) begin
				result_ready <= 1'b0;
				rx_left <= $urandom_range(1, 3);
			end else begin
				result_ready <= 1'b0;
				rx_left <= $urandom_range(5, 20);
			end
		end else begin
			rx_left <= rx_left - 1;
		end
	end

	// Monitor: tracks register writes, predicts each accepted request and checks verdicts.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pat_lo_q = '0;
			pat_hi_q = '0;
			pat_len_q = '0;
			live_pos = start_positions();
			text_fire <= 1'b0;
		end else begin
			text_fire <= text_valid && text_ready;
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			if (result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict with no request waiting: matches_here %0b, was_last %0b",
						result.matches_here, result.was_last);
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (result.matches_here !== want.matches_here) begin
						$error("matches_here: expected %0b, got %0b",
							want.matches_here, result.matches_here);
						fail_count++;
					end
					if (result.was_last !== want.was_last) begin
						$error("was_last: expected %0b, got %0b", want.was_last, result.was_last);
						fail_count++;
					end
				end
			end
			if (text_valid && text_ready) begin
				want.matches_here = advance_positions(text.text_byte, text.is_last);
				want.was_last = text.is_last;
				expected_verdicts.push_back(want);
				items_taken++;
			end
		end
	end

	initial begin : stimulus
		int random_items;
		int phase_target;
		int phase_start;
		random_items = 0;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty pattern straight out of reset never matches.
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b1);
		wait_idle();

		// Leading star, a question mark, a zero literal, a literal 8'h62 and a trailing star.
		write_reg(CFG_PAT_LOW, {8'h00, 8'h00, 8'h00, CHAR_STAR, 8'h62, 8'h00, CHAR_ANY,
			CHAR_STAR});
		write_reg(CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_PAT_LEN, 64'd5);
		end_writes();
		push_text(8'h00, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'h62, 1'b1);
		push_text(8'hFF, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'h62, 1'b0);
		push_text(8'h62, 1'b1);
		// This string is cut short by the next register write.
		push_text(8'h00, 1'b0);
		wait_idle();

		// Oversized length saturates to a full pattern of question marks.
		write_reg(CFG_PAT_LOW, {8{CHAR_ANY}});
		write_reg(CFG_PAT_HIGH, {8{CHAR_ANY}});
		write_reg(CFG_PAT_LEN, 64'd31);
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		end_writes();
		for (int i = 0; i < 16; i++) begin
			push_text(i[0] ? 8'hFF : 8'h00, i == 15);
		end
		wait_idle();

		// Random patterns, each followed by a batch of mostly well-formed strings.
		while (random_items < 650) begin
			load_random_pattern();
			phase_target = $urandom_range(20, 60);
			phase_start = items_pushed;
			while (items_pushed - phase_start < phase_target) begin
				queue_string($urandom_range(0, 4) != 0);
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) push_text(text_pick(), 1'b0);
			end
			random_items += items_pushed - phase_start;
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: wildcard_glob_matcher_unit.f
design/wgm_pkg.sv
design/wgm_cell.sv
design/wgm_out_skid.sv
design/wildcard_glob_matcher_unit.sv
dv/testbench.sv
